### rtl/aafd_pkg.sv
// ADTS deframer shared package: queue sizing, queue entry type, header constants.
// No dependencies; imported by the front end, queue, output stage and top level.
package aafd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  SyncByte   = 8'hFF;
  localparam logic [3:0]  SyncNibble = 4'hF;
  localparam logic [12:0] HdrBytes   = 13'd7;

  localparam logic [2:0] PosRate  = 3'd2;
  localparam logic [2:0] PosLenHi = 3'd3;
  localparam logic [2:0] PosLenMd = 3'd4;
  localparam logic [2:0] PosLenLo = 3'd5;
  localparam logic [2:0] PosLast  = 3'd6;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
    logic [12:0] payload_length;
    logic        last_of_frame;
  } entry_t;

endpackage

### rtl/aafd_front.sv
// ADTS deframer front end: sync hunt, header capture, payload tagging.
// Depends on aafd_pkg; pushes tagged payload beats into aafd_queue.
module aafd_front
  import aafd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [1:0] {
    HUNT,
    HEADER,
    PAYLOAD
  } state_t;

  state_t      state;
  logic        prev_was_ff;
  logic [2:0]  header_pos;
  logic [3:0]  held_rate;
  logic [2:0]  held_ch;
  logic [12:0] frame_len;
  logic [12:0] plen;
  logic [12:0] bytes_left;
  logic        accept;
  logic        last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = (bytes_left <= 13'd1);
  assign push     = accept && (state == PAYLOAD);

  assign push_entry.payload_byte   = data_byte;
  assign push_entry.rate_index     = held_rate;
  assign push_entry.channel_config = held_ch;
  assign push_entry.payload_length = plen;
  assign push_entry.last_of_frame  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= HUNT;
      prev_was_ff <= 1'b0;
      header_pos  <= 3'd0;
      held_rate   <= 4'd0;
      held_ch     <= 3'd0;
      frame_len   <= 13'd0;
      plen        <= 13'd0;
      bytes_left  <= 13'd0;
    end else if (accept) begin
      case (state)
        HEADER: begin
          case (header_pos)
            PosRate: begin
              held_rate <= data_byte[5:2];
              held_ch   <= {data_byte[0], 2'b00};
            end
            PosLenHi: begin
              held_ch   <= {held_ch[2], data_byte[7:6]};
              frame_len <= {data_byte[1:0], 11'd0};
            end
            PosLenMd: frame_len <= {frame_len[12:11], data_byte, 3'd0};
            PosLenLo: frame_len <= {frame_len[12:3], data_byte[7:5]};
            default: ;
          endcase
          if (header_pos >= PosLast) begin
            header_pos  <= 3'd0;
            prev_was_ff <= 1'b0;
            if (frame_len <= HdrBytes) begin
              state <= HUNT;
            end else begin
              state      <= PAYLOAD;
              bytes_left <= frame_len - HdrBytes;
              plen       <= frame_len - HdrBytes;
            end
          end else begin
            header_pos <= header_pos + 3'd1;
          end
        end
        PAYLOAD: begin
          if (last) begin
            bytes_left  <= 13'd0;
            state       <= HUNT;
            prev_was_ff <= 1'b0;
            header_pos  <= 3'd0;
          end else begin
            bytes_left <= bytes_left - 13'd1;
          end
        end
        default: begin
          if (prev_was_ff && (data_byte[7:4] == SyncNibble)) begin
            state       <= HEADER;
            header_pos  <= PosRate;
            prev_was_ff <= 1'b0;
          end else begin
            state       <= HUNT;
            prev_was_ff <= (data_byte == SyncByte);
          end
        end
      endcase
    end
  end

endmodule

### rtl/aafd_queue.sv
// ADTS deframer beat queue between front end and output stage.
// Depends on aafd_pkg (entry_t, QueueDepth); small register FIFO.
module aafd_queue
  import aafd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t           mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == QCntW'(QueueDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/aafd_back.sv
// ADTS deframer output stage: registered result beat fed from the queue.
// Depends on aafd_pkg (entry_t).
module aafd_back
  import aafd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic [3:0]  rate_index,
  output logic [2:0]  channel_config,
  output logic [12:0] payload_length,
  output logic        last_of_frame
);

  entry_t held;

  assign pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  assign payload_byte   = held.payload_byte;
  assign rate_index     = held.rate_index;
  assign channel_config = held.channel_config;
  assign payload_length = held.payload_length;
  assign last_of_frame  = held.last_of_frame;

endmodule

### rtl/adts_aac_frame_deframer.sv
// ADTS AAC deframer top level: front end, beat queue, output stage.
// Depends on aafd_pkg, aafd_front, aafd_queue, aafd_back.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | data_byte
//  output  | out_valid / out_ready| payload_byte, rate_index, channel_config,
//          |                      | payload_length, last_of_frame
//
// One byte per clock while in_ready is high; each payload byte is written into the
// queue at the accepting edge and loaded into the output register once that is free.
// The two-entry queue sets stall behavior: in_ready drops only while it is
// full, so header and hunt bytes keep flowing during short output stalls.
// Synchronous reset returns the parser to sync hunt and empties the queue.
module adts_aac_frame_deframer
  import aafd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic [3:0]  rate_index,
  output logic [2:0]  channel_config,
  output logic [12:0] payload_length,
  output logic        last_of_frame
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  aafd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  aafd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  aafd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .rate_index     (rate_index),
    .channel_config (channel_config),
    .payload_length (payload_length),
    .last_of_frame  (last_of_frame)
  );

endmodule

### rtl/aafd_checker.sv
// ADTS deframer port checker and its bind to the top level.
// Depends only on the top-level ports; no package use.
module aafd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic [12:0] payload_length,
  input logic        last_of_frame
);

  logic [12:0] beat_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= 13'd0;
    end else if (out_valid && out_ready) begin
      beat_cnt <= last_of_frame ? 13'd0 : beat_cnt + 13'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte))
    else $error("output beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_frame == (beat_cnt + 13'd1 == payload_length)))
    else $error("last_of_frame not on final payload beat");

  a_len_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_frame ##1 out_valid
      |-> $stable(payload_length) || !$past(out_valid))
    else $error("payload_length changed inside a frame");

endmodule

bind adts_aac_frame_deframer aafd_checker u_aafd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .payload_byte   (payload_byte),
  .payload_length (payload_length),
  .last_of_frame  (last_of_frame)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for adts_aac_frame_deframer: directed ADTS beats, then random frames with noise.
// Output beats are checked vs a built-in model or typed rows. Depends on aafd_pkg and the RTL.
module tb_top
  import aafd_pkg::*;
();

  typedef enum logic [1:0] {SEEK = 2'd0, HDR = 2'd1, BODY = 2'd2} seek_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    entry_t     want;
  } dir_row_t;

  localparam int NumDirected = 26;
  localparam int RandomBeats = 1850;
  localparam int TailBeats   = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  payload_byte;
  logic [3:0]  rate_index;
  logic [2:0]  channel_config;
  logic [12:0] payload_length;
  logic        last_of_frame;

  adts_aac_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_byte(payload_byte), .rate_index(rate_index), .channel_config(channel_config),
    .payload_length(payload_length), .last_of_frame(last_of_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sync via FF FF, full header, two payload beats; then a short frame and an empty frame
  dir_row_t dir_tab [NumDirected] = '{
    {8'h00, 1'b0, 29'd0},
    {8'hFF, 1'b0, 29'd0},
    {8'h0F, 1'b0, 29'd0},
    {8'hFF, 1'b0, 29'd0},
    {8'hFF, 1'b0, 29'd0},
    {8'h3D, 1'b0, 29'd0},
    {8'hC0, 1'b0, 29'd0},
    {8'h01, 1'b0, 29'd0},
    {8'h20, 1'b0, 29'd0},
    {8'hFC, 1'b0, 29'd0},
    {8'h00, 1'b1, 8'h00, 4'hF, 3'd7, 13'd2, 1'b0},
    {8'hFF, 1'b1, 8'hFF, 4'hF, 3'd7, 13'd2, 1'b1},
    {8'hFF, 1'b0, 29'd0},
    {8'hF1, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'h60, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'hFF, 1'b0, 29'd0},
    {8'hF0, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'h00, 1'b0, 29'd0},
    {8'hE0, 1'b0, 29'd0},
    {8'hFF, 1'b0, 29'd0}
  };

  seek_phase_t st_phase;
  logic        ff_seen;
  logic [2:0]  hdr_idx;
  logic [3:0]  hdr_rate;
  logic [2:0]  hdr_chan;
  logic [12:0] hdr_flen;
  logic [12:0] body_left;

  dir_row_t offered_q [$];
  entry_t   expected_payload_q [$];
  int       mismatch_cnt = 0;
  int       beats_in = 0;

  function automatic void restart_seek();
    st_phase = SEEK;
    ff_seen  = 1'b0;
    hdr_idx  = 3'd0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, output logic got, output entry_t r);
    logic last;
    got = 1'b0;
    r   = '0;
    case (st_phase)
      HDR: begin
        case (hdr_idx)
          PosRate: begin
            hdr_rate = b[5:2];
            hdr_chan = {b[0], 2'b00};
          end
          PosLenHi: begin
            hdr_chan[1:0] = b[7:6];
            hdr_flen      = {b[1:0], 11'd0};
          end
          PosLenMd: hdr_flen[10:3] = b;
          PosLenLo: hdr_flen[2:0] = b[7:5];
          default: ;
        endcase
        if (hdr_idx >= PosLast) begin
          if (hdr_flen <= HdrBytes) begin
            restart_seek();
          end else begin
            body_left = hdr_flen - HdrBytes;
            st_phase  = BODY;
            hdr_idx   = 3'd0;
          end
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      BODY: begin
        last = (body_left <= 13'd1);
        got = 1'b1;
        r.payload_byte   = b;
        r.rate_index     = hdr_rate;
        r.channel_config = hdr_chan;
        r.payload_length = (hdr_flen >= HdrBytes) ? hdr_flen - HdrBytes : 13'd0;
        r.last_of_frame  = last;
        if (last) begin
          body_left = 13'd0;
          restart_seek();
        end else begin
          body_left = body_left - 13'd1;
        end
      end
      default: begin
        if (ff_seen && b[7:4] == SyncNibble) begin
          st_phase = HDR;
          hdr_idx  = PosRate;
          ff_seen  = 1'b0;
        end else begin
          st_phase = SEEK;
          ff_seen  = (b == SyncByte);
        end
      end
    endcase
  endfunction

  // mostly no idle, some short, a few long; occasional long calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 8) begin
      calm = $urandom_range(100, 300);
      return 0;
    end
    if (r < 500) return 0;
    if (r < 965) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int send_calm = 0;

  task automatic offer_beat(input logic [7:0] b, input logic typed, input entry_t want);
    int gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_q.push_back({b, typed, want});
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic offer_frame(input logic [12:0] flen, input int npay);
    logic [7:0] b;
    offer_beat(SyncByte, 1'b0, '0);
    offer_beat({SyncNibble, 4'($urandom)}, 1'b0, '0);
    offer_beat(8'($urandom), 1'b0, '0);
    b = 8'($urandom);
    offer_beat({b[7:2], flen[12:11]}, 1'b0, '0);
    offer_beat(flen[10:3], 1'b0, '0);
    b = 8'($urandom);
    offer_beat({flen[2:0], b[4:0]}, 1'b0, '0);
    offer_beat(8'($urandom), 1'b0, '0);
    repeat (npay) offer_beat(8'($urandom), 1'b0, '0);
  endtask

  // input beat accepted: advance the model, queue its result
  always @(posedge clk) begin : take_in
    dir_row_t row;
    logic     got;
    entry_t   r;
    if (!rst && in_valid && in_ready) begin
      row = offered_q.pop_front();
      beats_in++;
      deframe_byte(row.b, got, r);
      if (got) expected_payload_q.push_back(row.typed ? row.want : r);
    end
  end

  always @(posedge clk) begin : check_out
    entry_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_payload_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: byte %h rate %0d chan %0d len %0d last %0b",
                   payload_byte, rate_index, channel_config, payload_length, last_of_frame);
      end else begin
        w = expected_payload_q.pop_front();
        if (payload_byte !== w.payload_byte || rate_index !== w.rate_index ||
            channel_config !== w.channel_config || payload_length !== w.payload_length ||
            last_of_frame !== w.last_of_frame) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("beat mismatch: exp byte %h rate %0d chan %0d len %0d last %0b",
                     w.payload_byte, w.rate_index, w.channel_config, w.payload_length,
                     w.last_of_frame);
            $display("               got byte %h rate %0d chan %0d len %0d last %0b",
                     payload_byte, rate_index, channel_config, payload_length,
                     last_of_frame);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin : sink
    int  calm;
    int  n;
    bit  held;
    calm = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && beats_in > 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        n = idle_len(calm);
        if (n == 0) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("adts_aac_frame_deframer: mismatch");
    $finish;
  end

  initial begin : source
    int filled;
    int noise;
    int r;
    int flen;
    int npay;
    st_phase  = SEEK;
    ff_seen   = 1'b0;
    hdr_idx   = 3'd0;
    hdr_rate  = 4'd0;
    hdr_chan  = 3'd0;
    hdr_flen  = 13'd0;
    body_left = 13'd0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++)
      offer_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

    filled = 0;
    while (filled < RandomBeats) begin
      if ($urandom_range(0, 3) == 0) begin
        noise = $urandom_range(1, 4);
        repeat (noise)
          offer_beat(($urandom_range(0, 3) == 0) ? SyncByte : 8'($urandom), 1'b0, '0);
        filled += noise;
      end
      r = $urandom_range(0, 99);
      if (r < 75)      flen = $urandom_range(8, 40);
      else if (r < 87) flen = $urandom_range(0, 7);
      else             flen = $urandom_range(41, 300);
      npay = (flen > 7) ? flen - 7 : 0;
      // broken frame: cut the payload short
      if (npay > 0 && $urandom_range(0, 99) < 8) npay = $urandom_range(0, npay - 1);
      offer_frame(13'(flen), npay);
      filled += 7 + npay;
    end
    // longest length field; the stream ends inside this frame
    offer_frame(13'h1FFF, TailBeats);
    in_valid <= 1'b0;

    while (offered_q.size() != 0 || expected_payload_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("adts_aac_frame_deframer: match");
    else
      $display("adts_aac_frame_deframer: mismatch");
    $finish;
  end

endmodule
